// ===== hw/rtl/baro_pressure_temp_compensation_top_macros.svh =====
// Assertion macros for the barometer compensation block.
// Both macros expect signals named clk and rst_n in the scope where they are used.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_TOP_MACROS_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BARO_COMP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BARO_COMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/baro_comp_pkg.sv =====
// Shared types and constants for the barometer compensation block.
// Has no dependencies; the top level takes everything by scoped names.
`default_nettype none

package baro_comp_pkg;

    // One sample transaction: raw pressure (D1) and raw temperature (D2).
    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } sample_t;

    // One result transaction.
    typedef struct packed {
        logic signed [14:0] temperature_centideg;
        logic [16:0]        pressure_centimbar;
        logic               out_of_range;
    } result_t;

    // Calibration register indexes.
    typedef enum logic [2:0] {
        CFG_PRESSURE_SENS     = 3'd0,
        CFG_PRESSURE_OFFSET   = 3'd1,
        CFG_SENS_TEMP_COEFF   = 3'd2,
        CFG_OFFSET_TEMP_COEFF = 3'd3,
        CFG_REFERENCE_TEMP    = 3'd4,
        CFG_TEMP_COEFF        = 3'd5
    } cfg_index_t;

    // Factory defaults of the calibration words.
    localparam logic [15:0] RST_PRESSURE_SENS     = 16'd40127;
    localparam logic [15:0] RST_PRESSURE_OFFSET   = 16'd36924;
    localparam logic [15:0] RST_SENS_TEMP_COEFF   = 16'd23317;
    localparam logic [15:0] RST_OFFSET_TEMP_COEFF = 16'd23282;
    localparam logic [15:0] RST_REFERENCE_TEMP    = 16'd33464;
    localparam logic [15:0] RST_TEMP_COEFF        = 16'd28312;

    // Temperature thresholds in 0.01 C. COLD_DELTA is -35 C from 20 C (-15 C).
    localparam int TEMP_REF   = 2000;
    localparam int COLD_DELTA = -3500;

    // Saturation limits.
    localparam int T_MIN = -4000;
    localparam int T_MAX = 8500;
    localparam int P_MIN = 1000;
    localparam int P_MAX = 120000;

endpackage

`default_nettype wire

// ===== hw/rtl/baro_pressure_temp_compensation_top.sv =====
// Barometer second-order temperature compensation, ten-stage pipeline.
// Depends on baro_comp_pkg and baro_pressure_temp_compensation_top_macros.svh.
//
// Usage: a sample transaction (sample_valid/sample_ready, payload sample) carries one
// raw pressure and one raw temperature conversion. Each sample yields exactly one
// result transaction (result_valid/result_ready, payload result) with the compensated
// temperature in 0.01 C, the pressure in 0.01 mbar and a saturation flag.
// The six calibration words are written over the cfg channel (cfg_valid, cfg_index,
// cfg_data); cfg_ready is always high and unknown indexes are ignored. Writes are
// meant to happen only while no sample is in flight.
// Throughput is one sample per cycle while the receiver keeps up, set by the ten
// register stages that all advance together. When the receiver stalls on a
// pending result, the whole pipeline holds and sample_ready drops in the same
// cycle; no transaction is lost or repeated, bubbles stay in place.
// Reset clears every stage valid bit and loads the factory calibration defaults.
`default_nettype none
`include "baro_pressure_temp_compensation_top_macros.svh"

module baro_pressure_temp_compensation_top (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Sample channel
    input  wire logic                   sample_valid,
    output logic                        sample_ready,
    input  wire baro_comp_pkg::sample_t sample,
    // Result channel
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output baro_comp_pkg::result_t      result,
    // Calibration write channel
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [15:0]            cfg_data
);

    // ------------------------------------------------------------------
    // Calibration registers
    // ------------------------------------------------------------------
    logic [15:0] cal_pressure_sens_reg;
    logic [15:0] cal_pressure_offset_reg;
    logic [15:0] cal_sens_temp_coeff_reg;
    logic [15:0] cal_offset_temp_coeff_reg;
    logic [15:0] cal_reference_temp_reg;
    logic [15:0] cal_temp_coeff_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_pressure_sens_reg     <= baro_comp_pkg::RST_PRESSURE_SENS;
            cal_pressure_offset_reg   <= baro_comp_pkg::RST_PRESSURE_OFFSET;
            cal_sens_temp_coeff_reg   <= baro_comp_pkg::RST_SENS_TEMP_COEFF;
            cal_offset_temp_coeff_reg <= baro_comp_pkg::RST_OFFSET_TEMP_COEFF;
            cal_reference_temp_reg    <= baro_comp_pkg::RST_REFERENCE_TEMP;
            cal_temp_coeff_reg        <= baro_comp_pkg::RST_TEMP_COEFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (baro_comp_pkg::cfg_index_t'(cfg_index))
                baro_comp_pkg::CFG_PRESSURE_SENS:     cal_pressure_sens_reg     <= cfg_data;
                baro_comp_pkg::CFG_PRESSURE_OFFSET:   cal_pressure_offset_reg   <= cfg_data;
                baro_comp_pkg::CFG_SENS_TEMP_COEFF:   cal_sens_temp_coeff_reg   <= cfg_data;
                baro_comp_pkg::CFG_OFFSET_TEMP_COEFF: cal_offset_temp_coeff_reg <= cfg_data;
                baro_comp_pkg::CFG_REFERENCE_TEMP:    cal_reference_temp_reg    <= cfg_data;
                baro_comp_pkg::CFG_TEMP_COEFF:        cal_temp_coeff_reg        <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. All stages move together; the output register is
    // the last stage, so a sample enters whenever the result slot is free
    // or is being taken in this cycle.
    // ------------------------------------------------------------------
    logic       adv;
    logic [8:0] vld_reg;
    logic       result_valid_reg;

    assign adv          = !result_valid_reg || result_ready;
    assign sample_ready = adv;
    assign result_valid = result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg          <= {vld_reg[7:0], sample_valid};
            result_valid_reg <= vld_reg[8];
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers (no reset; qualified by the valid bits above)
    // ------------------------------------------------------------------
    // Stage 1: dT
    logic signed [24:0] s1_dt_reg;
    logic        [23:0] s1_d1_reg;
    // Stage 2: the four products of dT
    logic signed [41:0] s2_p6_reg;
    logic signed [41:0] s2_p4_reg;
    logic signed [41:0] s2_p3_reg;
    logic        [16:0] s2_t2_reg;
    logic        [23:0] s2_d1_reg;
    // Stage 3: first-order TEMP offset, OFF, SENS
    logic signed [17:0] s3_dtemp_reg;
    logic signed [35:0] s3_off1_reg;
    logic signed [34:0] s3_sens1_reg;
    logic        [16:0] s3_t2_reg;
    logic        [23:0] s3_d1_reg;
    // Stage 4: squares for the second-order terms
    logic        [34:0] s4_sqa_reg;
    logic        [35:0] s4_sqb_reg;
    logic               s4_low_reg;
    logic               s4_cold_reg;
    logic signed [19:0] s4_temp2_reg;
    logic signed [35:0] s4_off1_reg;
    logic signed [34:0] s4_sens1_reg;
    logic        [23:0] s4_d1_reg;
    // Stage 5: second-order correction terms, saturated temperature
    logic        [35:0] s5_off2a_reg;
    logic        [38:0] s5_off2b_reg;
    logic        [34:0] s5_sens2a_reg;
    logic        [38:0] s5_sens2b_reg;
    logic signed [35:0] s5_off1_reg;
    logic signed [34:0] s5_sens1_reg;
    logic signed [14:0] s5_tsat_reg;
    logic               s5_tflag_reg;
    logic        [23:0] s5_d1_reg;
    // Stage 6: final OFF and SENS
    logic signed [40:0] s6_off_reg;
    logic signed [40:0] s6_sens_reg;
    logic signed [14:0] s6_tsat_reg;
    logic               s6_tflag_reg;
    logic        [23:0] s6_d1_reg;
    // Stage 7: partial products of D1 * SENS
    logic        [43:0] s7_plo_reg;
    logic signed [45:0] s7_phi_reg;
    logic signed [40:0] s7_off_reg;
    logic signed [14:0] s7_tsat_reg;
    logic               s7_tflag_reg;
    // Stage 8: full product
    logic signed [64:0] s8_prod_reg;
    logic signed [40:0] s8_off_reg;
    logic signed [14:0] s8_tsat_reg;
    logic               s8_tflag_reg;
    // Stage 9: D1*SENS/2^21 - OFF
    logic signed [44:0] s9_q_reg;
    logic signed [14:0] s9_tsat_reg;
    logic               s9_tflag_reg;
    // Stage 10: output register
    baro_comp_pkg::result_t result_reg;

    // ------------------------------------------------------------------
    // Next-value logic
    // ------------------------------------------------------------------
    // Stage 1: dT = D2 - C5 * 2^8.
    logic signed [24:0] s1_dt_next;
    assign s1_dt_next = $signed({1'b0, sample.raw_temperature})
                      - $signed({1'b0, cal_reference_temp_reg, 8'd0});

    // Stage 2: one multiplier per term. dT^2 / 2^31 is a bit slice.
    logic signed [41:0] s2_p6_next;
    logic signed [41:0] s2_p4_next;
    logic signed [41:0] s2_p3_next;
    logic signed [49:0] s2_dtsq;
    assign s2_p6_next = s1_dt_reg * $signed({1'b0, cal_temp_coeff_reg});
    assign s2_p4_next = s1_dt_reg * $signed({1'b0, cal_offset_temp_coeff_reg});
    assign s2_p3_next = s1_dt_reg * $signed({1'b0, cal_sens_temp_coeff_reg});
    assign s2_dtsq    = s1_dt_reg * s1_dt_reg;

    // Stage 3: arithmetic shifts round toward minus infinity, as required.
    logic signed [17:0] s3_dtemp_next;
    logic signed [35:0] s3_off1_next;
    logic signed [34:0] s3_sens1_next;
    assign s3_dtemp_next = $signed(s2_p6_reg[40:23]);
    assign s3_off1_next  = $signed({4'd0, cal_pressure_offset_reg, 16'd0})
                         + $signed(s2_p4_reg[41:7]);
    assign s3_sens1_next = $signed({4'd0, cal_pressure_sens_reg, 15'd0})
                         + $signed(s2_p3_reg[41:8]);

    // Stage 4: (TEMP - 2000)^2 and (TEMP + 1500)^2. The range tests use the
    // first-order temperature. T2 only applies below 20 C.
    logic signed [35:0] s4_sqa_full;
    logic signed [18:0] s4_cold_diff;
    logic signed [37:0] s4_sqb_full;
    logic        [16:0] s4_t2_used;
    logic signed [19:0] s4_temp2_next;
    assign s4_sqa_full   = s3_dtemp_reg * s3_dtemp_reg;
    assign s4_cold_diff  = 19'(s3_dtemp_reg) - 19'(baro_comp_pkg::COLD_DELTA);
    assign s4_sqb_full   = s4_cold_diff * s4_cold_diff;
    assign s4_t2_used    = (s3_dtemp_reg < 18'sd0) ? s3_t2_reg : 17'd0;
    assign s4_temp2_next = 20'(baro_comp_pkg::TEMP_REF) + 20'(s3_dtemp_reg)
                         - $signed({3'd0, s4_t2_used});

    // Stage 5: constant multiples by shift and add, gated by the range tests.
    logic        [36:0] s5_sqa_x5;
    logic        [38:0] s5_sqb_x7;
    logic        [39:0] s5_sqb_x11;
    logic               s5_tlow;
    logic               s5_thigh;
    logic signed [14:0] s5_tsat_next;
    assign s5_sqa_x5  = {s4_sqa_reg, 2'b00} + 37'(s4_sqa_reg);
    assign s5_sqb_x7  = {s4_sqb_reg, 3'b000} - 39'(s4_sqb_reg);
    assign s5_sqb_x11 = 40'({s4_sqb_reg, 3'b000}) + 40'({s4_sqb_reg, 1'b0})
                      + 40'(s4_sqb_reg);
    assign s5_tlow    = s4_temp2_reg < 20'(baro_comp_pkg::T_MIN);
    assign s5_thigh   = s4_temp2_reg > 20'(baro_comp_pkg::T_MAX);

    always_comb
    begin
        priority if (s5_tlow)
            s5_tsat_next = 15'(baro_comp_pkg::T_MIN);
        else if (s5_thigh)
            s5_tsat_next = 15'(baro_comp_pkg::T_MAX);
        else
            s5_tsat_next = s4_temp2_reg[14:0];
    end

    // Stage 6: OFF - OFF2 and SENS - SENS2, three operands each.
    logic signed [40:0] s6_off_next;
    logic signed [40:0] s6_sens_next;
    assign s6_off_next  = 41'(s5_off1_reg) - 41'(s5_off2a_reg) - 41'(s5_off2b_reg);
    assign s6_sens_next = 41'(s5_sens1_reg) - 41'(s5_sens2a_reg) - 41'(s5_sens2b_reg);

    // Stage 7: D1 * SENS split at bit 20 of SENS into two narrow multipliers.
    logic        [43:0] s7_plo_next;
    logic signed [45:0] s7_phi_next;
    assign s7_plo_next = s6_d1_reg * s6_sens_reg[19:0];
    assign s7_phi_next = $signed({1'b0, s6_d1_reg}) * $signed(s6_sens_reg[40:20]);

    // Stage 8: recombine the partial products.
    logic signed [65:0] s8_prod_full;
    assign s8_prod_full = $signed({s7_phi_reg, 20'd0}) + $signed({22'd0, s7_plo_reg});

    // Stage 9: D1 * SENS / 2^21 - OFF.
    logic signed [44:0] s9_q_next;
    assign s9_q_next = 45'($signed(s8_prod_reg[64:21])) - 45'(s8_off_reg);

    // Stage 10: divide by 2^15 and saturate the pressure.
    logic signed [29:0]     s10_p;
    logic                   s10_plow;
    logic                   s10_phigh;
    baro_comp_pkg::result_t result_next;
    assign s10_p     = $signed(s9_q_reg[44:15]);
    assign s10_plow  = s10_p < 30'(baro_comp_pkg::P_MIN);
    assign s10_phigh = s10_p > 30'(baro_comp_pkg::P_MAX);

    always_comb
    begin
        result_next.temperature_centideg = s9_tsat_reg;
        result_next.out_of_range         = s9_tflag_reg || s10_plow || s10_phigh;
        priority if (s10_plow)
            result_next.pressure_centimbar = 17'(baro_comp_pkg::P_MIN);
        else if (s10_phigh)
            result_next.pressure_centimbar = 17'(baro_comp_pkg::P_MAX);
        else
            result_next.pressure_centimbar = s10_p[16:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_dt_reg     <= s1_dt_next;
            s1_d1_reg     <= sample.raw_pressure;

            s2_p6_reg     <= s2_p6_next;
            s2_p4_reg     <= s2_p4_next;
            s2_p3_reg     <= s2_p3_next;
            s2_t2_reg     <= s2_dtsq[47:31];
            s2_d1_reg     <= s1_d1_reg;

            s3_dtemp_reg  <= s3_dtemp_next;
            s3_off1_reg   <= s3_off1_next;
            s3_sens1_reg  <= s3_sens1_next;
            s3_t2_reg     <= s2_t2_reg;
            s3_d1_reg     <= s2_d1_reg;

            s4_sqa_reg    <= s4_sqa_full[34:0];
            s4_sqb_reg    <= s4_sqb_full[35:0];
            s4_low_reg    <= s3_dtemp_reg < 18'sd0;
            s4_cold_reg   <= s3_dtemp_reg < 18'(baro_comp_pkg::COLD_DELTA);
            s4_temp2_reg  <= s4_temp2_next;
            s4_off1_reg   <= s3_off1_reg;
            s4_sens1_reg  <= s3_sens1_reg;
            s4_d1_reg     <= s3_d1_reg;

            s5_off2a_reg  <= s4_low_reg ? s5_sqa_x5[36:1] : '0;
            s5_sens2a_reg <= s4_low_reg ? s5_sqa_x5[36:2] : '0;
            s5_off2b_reg  <= s4_cold_reg ? s5_sqb_x7 : '0;
            s5_sens2b_reg <= s4_cold_reg ? s5_sqb_x11[39:1] : '0;
            s5_off1_reg   <= s4_off1_reg;
            s5_sens1_reg  <= s4_sens1_reg;
            s5_tsat_reg   <= s5_tsat_next;
            s5_tflag_reg  <= s5_tlow || s5_thigh;
            s5_d1_reg     <= s4_d1_reg;

            s6_off_reg    <= s6_off_next;
            s6_sens_reg   <= s6_sens_next;
            s6_tsat_reg   <= s5_tsat_reg;
            s6_tflag_reg  <= s5_tflag_reg;
            s6_d1_reg     <= s5_d1_reg;

            s7_plo_reg    <= s7_plo_next;
            s7_phi_reg    <= s7_phi_next;
            s7_off_reg    <= s6_off_reg;
            s7_tsat_reg   <= s6_tsat_reg;
            s7_tflag_reg  <= s6_tflag_reg;

            s8_prod_reg   <= s8_prod_full[64:0];
            s8_off_reg    <= s7_off_reg;
            s8_tsat_reg   <= s7_tsat_reg;
            s8_tflag_reg  <= s7_tflag_reg;

            s9_q_reg      <= s9_q_next;
            s9_tsat_reg   <= s8_tsat_reg;
            s9_tflag_reg  <= s8_tflag_reg;

            result_reg    <= result_next;
        end
    end

    assign result = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic result_in_range;
    assign result_in_range =
        (result.temperature_centideg >= 15'(baro_comp_pkg::T_MIN))
        && (result.temperature_centideg <= 15'(baro_comp_pkg::T_MAX))
        && (result.pressure_centimbar >= 17'(baro_comp_pkg::P_MIN))
        && (result.pressure_centimbar <= 17'(baro_comp_pkg::P_MAX));

    // A delivered result always lies inside the saturation window.
    `BARO_COMP_ASSERT_SAME(a_result_in_range, result_valid, result_in_range, "result outside saturation range")
    // While the pipeline is frozen, no stage gains or loses a transaction.
    `BARO_COMP_ASSERT_NEXT(a_stall_freezes_pipe, !adv, $stable(vld_reg) && $stable(result_valid_reg), "pipeline occupancy changed during a stall")

endmodule

`default_nettype wire

// ===== tb/tb_baro_pressure_temp_compensation_top.sv =====
// Self-checking testbench for the barometer second-order compensation pipeline.
// Depends on baro_comp_pkg and the baro_pressure_temp_compensation_top RTL; it
// predicts every result in a small scoreboard class and drives the ports with tasks.
`default_nettype none

module tb_baro_pressure_temp_compensation_top;

    localparam int NUM_CAL_WORDS = 6;
    localparam int FLUSH_CYCLES  = 12;       // a little more than the ten-stage pipeline depth
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int LONG_HOLD     = 200;      // receiver back-pressure stretch, in cycles
    localparam int HOLD_AFTER    = 600;      // results checked before the long hold
    localparam int NUM_PHASES    = 9;

    // Indexes that select no calibration word; writes to them must be dropped.
    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;

    localparam logic [15:0] CAL_DEFAULTS [NUM_CAL_WORDS] = '{
        baro_comp_pkg::RST_PRESSURE_SENS, baro_comp_pkg::RST_PRESSURE_OFFSET,
        baro_comp_pkg::RST_SENS_TEMP_COEFF, baro_comp_pkg::RST_OFFSET_TEMP_COEFF,
        baro_comp_pkg::RST_REFERENCE_TEMP, baro_comp_pkg::RST_TEMP_COEFF
    };

    // Random items per calibration phase; phase 0 also carries the directed items.
    localparam int PHASE_ITEMS [NUM_PHASES] = '{150, 100, 100, 100, 100, 400, 200, 200, 200};

    // Keeps a private copy of the calibration words, predicts the compensated
    // output of each accepted sample and compares results against that queue.
    class compensation_scoreboard;
        logic [15:0]            cal_word [NUM_CAL_WORDS];
        baro_comp_pkg::result_t expected_q [$];
        int unsigned            errors;
        int unsigned            checked;

        function void load_defaults();
            for (int i = 0; i < NUM_CAL_WORDS; i++)
                cal_word[i] = CAL_DEFAULTS[i];
        endfunction

        function void write_cal(logic [2:0] idx, logic [15:0] data);
            if (idx <= baro_comp_pkg::CFG_TEMP_COEFF)
                cal_word[idx] = data;
        endfunction

        // Datasheet compensation in 64-bit signed arithmetic; >>> floors.
        function baro_comp_pkg::result_t compensate(baro_comp_pkg::sample_t s);
            longint  d1, d2, c1, c2, c3, c4, c5, c6;
            longint  dt, temp, off, sens, t2, off2, sens2, sq, p, cold;
            bit      sat;
            baro_comp_pkg::result_t r;
            d1 = s.raw_pressure;
            d2 = s.raw_temperature;
            c1 = cal_word[baro_comp_pkg::CFG_PRESSURE_SENS];
            c2 = cal_word[baro_comp_pkg::CFG_PRESSURE_OFFSET];
            c3 = cal_word[baro_comp_pkg::CFG_SENS_TEMP_COEFF];
            c4 = cal_word[baro_comp_pkg::CFG_OFFSET_TEMP_COEFF];
            c5 = cal_word[baro_comp_pkg::CFG_REFERENCE_TEMP];
            c6 = cal_word[baro_comp_pkg::CFG_TEMP_COEFF];
            cold = baro_comp_pkg::TEMP_REF + baro_comp_pkg::COLD_DELTA;

            dt   = d2 - c5 * 256;
            temp = baro_comp_pkg::TEMP_REF + ((dt * c6) >>> 23);
            off  = c2 * 65536 + ((c4 * dt) >>> 7);
            sens = c1 * 32768 + ((c3 * dt) >>> 8);
            t2    = 0;
            off2  = 0;
            sens2 = 0;
            // Both thresholds are tested on the first-order temperature.
            if (temp < baro_comp_pkg::TEMP_REF) begin
                t2    = (dt * dt) >>> 31;
                sq    = (temp - baro_comp_pkg::TEMP_REF) * (temp - baro_comp_pkg::TEMP_REF);
                off2  = (5 * sq) >>> 1;
                sens2 = (5 * sq) >>> 2;
                if (temp < cold) begin
                    sq    = (temp - cold) * (temp - cold);
                    off2  = off2 + 7 * sq;
                    sens2 = sens2 + ((11 * sq) >>> 1);
                end
            end
            temp = temp - t2;
            off  = off - off2;
            sens = sens - sens2;
            p    = (((d1 * sens) >>> 21) - off) >>> 15;

            sat = 1'b0;
            if (temp < baro_comp_pkg::T_MIN) begin temp = baro_comp_pkg::T_MIN; sat = 1'b1; end
            if (temp > baro_comp_pkg::T_MAX) begin temp = baro_comp_pkg::T_MAX; sat = 1'b1; end
            if (p < baro_comp_pkg::P_MIN) begin p = baro_comp_pkg::P_MIN; sat = 1'b1; end
            if (p > baro_comp_pkg::P_MAX) begin p = baro_comp_pkg::P_MAX; sat = 1'b1; end

            r.temperature_centideg = temp[14:0];
            r.pressure_centimbar   = p[16:0];
            r.out_of_range         = sat;
            return r;
        endfunction

        function void note_sample(baro_comp_pkg::sample_t s);
            expected_q.push_back(compensate(s));
        endfunction

        function void check_result(baro_comp_pkg::result_t r);
            baro_comp_pkg::result_t e;
            if (expected_q.size() == 0) begin
                $error("result transaction arrived with no sample waiting for it");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (r.temperature_centideg !== e.temperature_centideg) begin
                $error("temperature_centideg: expected %0d, actual %0d",
                       e.temperature_centideg, r.temperature_centideg);
                errors++;
            end
            if (r.pressure_centimbar !== e.pressure_centimbar) begin
                $error("pressure_centimbar: expected %0d, actual %0d",
                       e.pressure_centimbar, r.pressure_centimbar);
                errors++;
            end
            if (r.out_of_range !== e.out_of_range) begin
                $error("out_of_range: expected %0b, actual %0b",
                       e.out_of_range, r.out_of_range);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   sample_valid;
    logic                   sample_ready;
    baro_comp_pkg::sample_t sample;
    logic                   result_valid;
    logic                   result_ready;
    baro_comp_pkg::result_t result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [2:0]             cfg_index;
    logic [15:0]            cfg_data;

    compensation_scoreboard sb;
    int unsigned cycle_count;

    baro_pressure_temp_compensation_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Free-running cycle count; the watchdog below ends a run that hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Observer: every handshake is seen at the clock edge where it completes.
    // Calibration writes update the scoreboard's copy, accepted samples queue a
    // prediction, and accepted results are checked against the oldest one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_cal(cfg_index, cfg_data);
            if (sample_valid && sample_ready)
                sb.note_sample(sample);
            if (result_valid && result_ready)
                sb.check_result(result);
        end
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint clamp24(longint v);
        if (v < 0)
            return 0;
        if (v > 24'hFFFFFF)
            return 24'hFFFFFF;
        return v;
    endfunction

    // Random sample. A fifth of them are raw noise over the full 24 bits; the
    // rest aim the temperature near the calibrated reference and pick a raw
    // pressure that lands inside the output range, so the second-order paths
    // and unsaturated pressures are exercised under every calibration set.
    function automatic baro_comp_pkg::sample_t make_sample();
        baro_comp_pkg::sample_t s;
        longint  c1, c2, c5, v;
        s.raw_pressure    = 24'($urandom);
        s.raw_temperature = 24'($urandom);
        if ($urandom_range(0, 9) >= 2)
        begin
            c1 = sb.cal_word[baro_comp_pkg::CFG_PRESSURE_SENS];
            c2 = sb.cal_word[baro_comp_pkg::CFG_PRESSURE_OFFSET];
            c5 = sb.cal_word[baro_comp_pkg::CFG_REFERENCE_TEMP];
            if ($urandom_range(0, 3) == 0)
                v = c5 * 256 + longint'($urandom_range(0, 1 << 25)) - (1 << 24);
            else
                v = c5 * 256 + longint'($urandom_range(0, 1 << 22)) - (1 << 21);
            s.raw_temperature = 24'(clamp24(v));
            if (c1 != 0)
            begin
                v = ((longint'($urandom_range(0, 130000)) + 2 * c2) <<< 21) / c1;
                s.raw_pressure = 24'(clamp24(v));
            end
        end
        return s;
    endfunction

    // Offers one sample after an optional idle gap and returns at the edge
    // where it is accepted. Valid stays high when the next call has no gap.
    task automatic send_sample(input baro_comp_pkg::sample_t s, input int gap);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
    endtask

    // One register write; cfg_valid is left high for a following write.
    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Writes all six calibration words, then a stray write to an unused index
    // that must change nothing. The stray write comes last so that a decoder
    // which aliases it onto a real word cannot be hidden by a later write.
    task automatic load_cal_words(input logic [15:0] words [NUM_CAL_WORDS]);
        for (int i = 0; i < NUM_CAL_WORDS; i++)
            cfg_write(3'(i), words[i]);
        cfg_write(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every predicted result has been checked, then lets the
    // pipeline run empty for a flush period.
    task automatic drain();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (FLUSH_CYCLES) @(posedge clk);
    endtask

    // Directed samples under the factory calibration: all-zero and all-one raw
    // words, checkerboards, a typical reading, the 20 C boundary (dT of zero and
    // just below), the -15 C boundary (first-order temperature of exactly -1500
    // and -1501), hot and cold saturation, and the raw pressure extremes.
    task automatic run_directed();
        logic [23:0]            raw_p [17];
        logic [23:0]            raw_t [17];
        baro_comp_pkg::sample_t s;
        raw_p = '{24'd0, 24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'hAAAAAA, 24'h555555,
                  24'd9085466, 24'd9085466, 24'd9085466, 24'd9085466, 24'd9085466,
                  24'd9085466, 24'd9085466, 24'd1, 24'hFFFFFF, 24'h800000, 24'h7FFFFF};
        raw_t = '{24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'h555555, 24'hAAAAAA,
                  24'd8569150, 24'd8566784, 24'd8566783, 24'd7529764, 24'd7529763,
                  24'd10566784, 24'd1000000, 24'd8569150, 24'd8569150, 24'd8569150,
                  24'd8569150};
        for (int i = 0; i < 17; i++)
        begin
            s.raw_pressure    = raw_p[i];
            s.raw_temperature = raw_t[i];
            send_sample(s, pick_gap());
        end
    endtask

    // Receiver: alternates random stalls with runs of readiness, some of them
    // long. Once, after a few hundred results, it holds off for a long stretch
    // while the sender keeps offering, so the pipeline fills and the sample
    // channel must stall. The trigger point falls well inside the long phase,
    // so the sender is still busy when the hold starts.
    initial
    begin : result_sink
        int stall;
        int run;
        bit long_hold_done;
        long_hold_done = 1'b0;
        result_ready   = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && sb.checked >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                stall = LONG_HOLD;
            end
            else
                stall = pick_gap() + 1;
            result_ready <= 1'b0;
            repeat (stall) @(posedge clk);
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 20);
            result_ready <= 1'b1;
            repeat (run) @(posedge clk);
        end
    end

    // Main sequence: reset, then nine calibration phases. Phase 0 runs on the
    // reset defaults; later phases load all zeros, all ones, two mixed-extreme
    // sets, the defaults written explicitly, and random sets. Calibration is
    // only changed once the pipeline has drained.
    initial
    begin : stimulus
        logic [15:0] words [NUM_CAL_WORDS];
        bit          burst;
        sb = new();
        sb.load_defaults();
        cycle_count  = 0;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        burst        = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                for (int i = 0; i < NUM_CAL_WORDS; i++)
                begin
                    case (ph)
                        1: words[i] = 16'h0000;
                        2: words[i] = 16'hFFFF;
                        3: words[i] = (i % 2 == 0) ? 16'hFFFF : 16'h0000;
                        4: words[i] = (i % 2 == 0) ? 16'h0000 : 16'hFFFF;
                        5: words[i] = CAL_DEFAULTS[i];
                        default:
                            words[i] = ($urandom_range(0, 1) != 0) ? 16'($urandom)
                                     : CAL_DEFAULTS[i] + 16'($urandom_range(0, 8191)) - 16'd4096;
                    endcase
                end
                load_cal_words(words);
            end
            if (ph == 0)
                run_directed();
            for (int n = 0; n < PHASE_ITEMS[ph]; n++)
            begin
                // Some stretches run back to back with no idle cycles at all.
                if (n % 64 == 0)
                    burst = ($urandom_range(0, 4) == 0);
                send_sample(make_sample(), burst ? 0 : pick_gap());
            end
            sample_valid <= 1'b0;
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/baro_comp_pkg.sv
hw/rtl/baro_pressure_temp_compensation_top.sv
tb/tb_baro_pressure_temp_compensation_top.sv
